// ===== rtl/irseg_pkg.sv =====
// irseg_pkg: shared types, widths and calibration table for the IR scan segmenter.
// No dependencies; used by every module in rtl/.
`default_nettype none

package irseg_pkg;

    localparam int RAW_W        = 12;
    localparam int ANGLE_W      = 8;
    localparam int DIST_W       = 6;
    localparam int TALLY_W      = 5;
    localparam int THR_W        = 6;
    localparam int CAL_POINTS   = 15;
    localparam int SEG_W        = 4;
    localparam int RISE_W       = 2;
    localparam int DEN_W        = 8;
    localparam int NUM_W        = RISE_W + DEN_W;
    localparam int DIV_STEPS    = NUM_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;

    localparam int DEF_MAX_OBJECTS = 16;
    localparam int DEF_MAX_ANGLE   = 180;

    localparam logic [THR_W-1:0]      THRESHOLD_RESET = THR_W'(50);
    localparam logic [APB_ADDR_W-1:0] ADDR_THRESHOLD  = APB_ADDR_W'(0);

    typedef struct packed {
        logic [RAW_W-1:0]   raw_ir;
        logic [ANGLE_W-1:0] angle;
        logic               first_of_sweep;
        logic               last_of_sweep;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0]  distance_cm;
        logic               object_closed;
        logic [ANGLE_W-1:0] closed_start_angle;
        logic [ANGLE_W-1:0] closed_end_angle;
        logic [DIST_W-1:0]  closed_distance;
        logic [TALLY_W-1:0] objects_found;
        logic               sweep_done;
        logic               smallest_valid;
        logic [ANGLE_W-1:0] smallest_start;
        logic [ANGLE_W-1:0] smallest_end;
        logic [DIST_W-1:0]  smallest_distance;
    } t_out_item;

    // request into the segmentation unit
    typedef struct packed {
        logic               first;
        logic               last;
        logic [ANGLE_W-1:0] angle;
        logic [DIST_W-1:0]  dist_cm;
    } t_seg_req;

    typedef struct packed {
        logic               done;
        logic [NUM_W-1:0]   quot;
    } t_div_rsp;

    function automatic logic [RAW_W-1:0] cal_raw(input logic [SEG_W-1:0] idx);
        logic [RAW_W-1:0] v;
        case (idx)
            4'd0:    v = 12'd1499;
            4'd1:    v = 12'd1277;
            4'd2:    v = 12'd1147;
            4'd3:    v = 12'd1087;
            4'd4:    v = 12'd987;
            4'd5:    v = 12'd955;
            4'd6:    v = 12'd919;
            4'd7:    v = 12'd877;
            4'd8:    v = 12'd842;
            4'd9:    v = 12'd833;
            4'd10:   v = 12'd803;
            4'd11:   v = 12'd795;
            4'd12:   v = 12'd779;
            4'd13:   v = 12'd751;
            4'd14:   v = 12'd731;
            default: v = 12'd731;
        endcase
        return v;
    endfunction

    function automatic logic [DIST_W-1:0] cal_cm(input logic [SEG_W-1:0] idx);
        logic [DIST_W-1:0] v;
        case (idx)
            4'd0:    v = 6'd9;
            4'd1:    v = 6'd12;
            4'd2:    v = 6'd15;
            4'd3:    v = 6'd18;
            4'd4:    v = 6'd21;
            4'd5:    v = 6'd24;
            4'd6:    v = 6'd27;
            4'd7:    v = 6'd30;
            4'd8:    v = 6'd33;
            4'd9:    v = 6'd36;
            4'd10:   v = 6'd39;
            4'd11:   v = 6'd42;
            4'd12:   v = 6'd45;
            4'd13:   v = 6'd48;
            4'd14:   v = 6'd50;
            default: v = 6'd50;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ir_scan_object_segmenter_core.sv =====
// ir_scan_object_segmenter_core: top level, sequencer, calibration lookup, APB register.
// Depends on irseg_pkg, irseg_div, irseg_seg.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+---------------------------
//  in       | input     | i_in_valid / o_in_ready     | i_in_item  (t_in_item)
//  out      | output    | o_out_valid / i_out_ready   | o_out_item (t_out_item)
//  cfg      | input     | psel, penable, pwrite       | paddr, pwdata / prdata
//
// A request runs from acceptance to result through S_LOAD (segment lookup, divider
// start), S_DIV (DIV_STEPS (10) quotient bits in the divider, then its done flag) and
// S_POST (update). The divider's one-bit-per-cycle loop sets the pace; o_in_ready is
// high only when idle, so a new request is taken only after the last leaves S_POST.
// The result sits in an output register, so a new request is taken while it waits;
// a stalled result holds the update cycle until it drains.
// Synchronous active-low reset; threshold resets to 50 cm, sweep state to zero.
`default_nettype none

module ir_scan_object_segmenter_core #(
    parameter int MAX_OBJECTS = irseg_pkg::DEF_MAX_OBJECTS,
    parameter int MAX_ANGLE   = irseg_pkg::DEF_MAX_ANGLE
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire irseg_pkg::t_in_item              i_in_item,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output irseg_pkg::t_out_item                  o_out_item,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [irseg_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [irseg_pkg::APB_DATA_W-1:0] pwdata,
    output logic [irseg_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                  pready
);

    localparam logic [irseg_pkg::ANGLE_W-1:0] ANGLE_MAX = irseg_pkg::ANGLE_W'(MAX_ANGLE);
    localparam logic [irseg_pkg::SEG_W-1:0]   SEG_LAST  =
        irseg_pkg::SEG_W'(irseg_pkg::CAL_POINTS - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_DIV  = 4'b0100,
        S_POST = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    irseg_pkg::t_in_item             r_item;
    logic [irseg_pkg::DIST_W-1:0]    r_base;
    logic [irseg_pkg::THR_W-1:0]     r_threshold;
    logic                            r_out_valid;
    irseg_pkg::t_out_item            r_out_item;

    logic                            in_acc, out_free, upd, div_start;
    irseg_pkg::t_in_item             in_sat;
    logic                            clamp_near, clamp_far;
    logic [irseg_pkg::SEG_W-1:0]     seg, seg_next;
    logic [irseg_pkg::DIST_W-1:0]    rise_full, base;
    logic [irseg_pkg::RISE_W-1:0]    rise;
    logic [irseg_pkg::DEN_W-1:0]     diff, span;
    logic [irseg_pkg::NUM_W-1:0]     num;
    logic [irseg_pkg::DEN_W-1:0]     den;
    irseg_pkg::t_div_rsp             div_rsp;
    irseg_pkg::t_seg_req             seg_req;
    irseg_pkg::t_out_item            seg_res;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;
    assign upd        = (r_state == S_POST) && out_free;
    assign div_start  = (r_state == S_LOAD);

    // angle saturates before capture
    always_comb begin
        in_sat = i_in_item;
        if (i_in_item.angle > ANGLE_MAX) begin
            in_sat.angle = ANGLE_MAX;
        end
    end

    // segment lookup: last table point the sample is still at or below
    always_comb begin
        seg = '0;
        for (int k = 0; k < irseg_pkg::CAL_POINTS - 1; k++) begin
            if (r_item.raw_ir <= irseg_pkg::cal_raw(irseg_pkg::SEG_W'(k))) begin
                seg = irseg_pkg::SEG_W'(k);
            end
        end
        seg_next   = irseg_pkg::SEG_W'(seg + 1'b1);
        clamp_near = r_item.raw_ir >= irseg_pkg::cal_raw('0);
        clamp_far  = r_item.raw_ir <= irseg_pkg::cal_raw(SEG_LAST);
        rise_full  = irseg_pkg::DIST_W'(irseg_pkg::cal_cm(seg_next) - irseg_pkg::cal_cm(seg));
        rise       = rise_full[irseg_pkg::RISE_W-1:0];
        diff       = irseg_pkg::DEN_W'(irseg_pkg::cal_raw(seg) - r_item.raw_ir);
        span       = irseg_pkg::DEN_W'(irseg_pkg::cal_raw(seg) - irseg_pkg::cal_raw(seg_next));
        if (clamp_near) begin
            num  = '0;
            den  = irseg_pkg::DEN_W'(1);
            base = irseg_pkg::cal_cm('0);
        end else if (clamp_far) begin
            num  = '0;
            den  = irseg_pkg::DEN_W'(1);
            base = irseg_pkg::cal_cm(SEG_LAST);
        end else begin
            num  = irseg_pkg::NUM_W'(rise * diff);
            den  = span;
            base = irseg_pkg::cal_cm(seg);
        end
    end

    irseg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (den),
        .o_rsp   (div_rsp)
    );

    assign seg_req.first   = r_item.first_of_sweep;
    assign seg_req.last    = r_item.last_of_sweep;
    assign seg_req.angle   = r_item.angle;
    assign seg_req.dist_cm = irseg_pkg::DIST_W'(r_base + div_rsp.quot[irseg_pkg::DIST_W-1:0]);

    irseg_seg #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_seg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_upd       (upd),
        .i_req       (seg_req),
        .i_threshold (r_threshold),
        .o_res       (seg_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) n_state = S_LOAD;
            S_LOAD:  n_state = S_DIV;
            S_DIV:   if (div_rsp.done) n_state = S_POST;
            S_POST:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_threshold <= irseg_pkg::THRESHOLD_RESET;
        end else begin
            r_state <= n_state;
            if (upd) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (psel && penable && pwrite && paddr == irseg_pkg::ADDR_THRESHOLD) begin
                r_threshold <= pwdata[irseg_pkg::THR_W-1:0];
            end
        end
        if (in_acc) begin
            r_item <= in_sat;
        end
        if (div_start) begin
            r_base <= base;
        end
        if (upd) begin
            r_out_item <= seg_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign pready      = 1'b1;
    assign prdata      = (paddr == irseg_pkg::ADDR_THRESHOLD) ?
                         irseg_pkg::APB_DATA_W'(r_threshold) : '0;

endmodule

`default_nettype wire

// ===== rtl/irseg_div.sv =====
// irseg_div: restoring shift-subtract divider, one quotient bit per cycle.
// Depends on irseg_pkg.
`default_nettype none

module irseg_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [irseg_pkg::NUM_W-1:0] i_num,
    input  wire logic [irseg_pkg::DEN_W-1:0] i_den,
    output irseg_pkg::t_div_rsp             o_rsp
);

    logic                              r_busy, n_busy;
    logic                              r_done, n_done;
    logic [irseg_pkg::DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic [irseg_pkg::NUM_W-1:0]       r_quo, n_quo;
    logic [irseg_pkg::DEN_W-1:0]       r_rem, n_rem;
    logic [irseg_pkg::DEN_W-1:0]       r_den, n_den;
    logic [irseg_pkg::DEN_W:0]         trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        trial  = {r_rem, r_quo[irseg_pkg::NUM_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = irseg_pkg::DEN_W'(trial - {1'b0, r_den});
                n_quo = {r_quo[irseg_pkg::NUM_W-2:0], 1'b1};
            end else begin
                n_rem = trial[irseg_pkg::DEN_W-1:0];
                n_quo = {r_quo[irseg_pkg::NUM_W-2:0], 1'b0};
            end
            n_cnt = irseg_pkg::DIV_CNT_W'(r_cnt + 1'b1);
            if (r_cnt == irseg_pkg::DIV_CNT_W'(irseg_pkg::DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

`default_nettype wire

// ===== rtl/irseg_seg.sv =====
// irseg_seg: object segmentation and narrowest-object tracking for one sweep.
// Depends on irseg_pkg; result fields are formed here, state moves on i_upd.
`default_nettype none

module irseg_seg #(
    parameter int MAX_OBJECTS = irseg_pkg::DEF_MAX_OBJECTS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_upd,
    input  wire irseg_pkg::t_seg_req         i_req,
    input  wire logic [irseg_pkg::THR_W-1:0] i_threshold,
    output irseg_pkg::t_out_item             o_res
);

    localparam logic [irseg_pkg::TALLY_W-1:0] TALLY_MAX = irseg_pkg::TALLY_W'(MAX_OBJECTS);

    logic                              r_inside, n_inside;
    logic [irseg_pkg::ANGLE_W-1:0]     r_open_start, n_open_start;
    logic [irseg_pkg::TALLY_W-1:0]     r_tally, n_tally;
    logic                              r_best_valid, n_best_valid;
    logic [irseg_pkg::ANGLE_W-1:0]     r_best_width, n_best_width;
    logic [irseg_pkg::ANGLE_W-1:0]     r_best_start, n_best_start;
    logic [irseg_pkg::ANGLE_W-1:0]     r_best_end, n_best_end;
    logic [irseg_pkg::DIST_W-1:0]      r_best_dist, n_best_dist;

    logic                              below, open_obj, close_obj, take;
    logic [irseg_pkg::ANGLE_W-1:0]     width;

    always_comb begin
        // start-of-sweep clears everything before the sample is applied
        if (i_req.first) begin
            n_inside     = 1'b0;
            n_open_start = '0;
            n_tally      = '0;
            n_best_valid = 1'b0;
            n_best_width = '0;
            n_best_start = '0;
            n_best_end   = '0;
            n_best_dist  = '0;
        end else begin
            n_inside     = r_inside;
            n_open_start = r_open_start;
            n_tally      = r_tally;
            n_best_valid = r_best_valid;
            n_best_width = r_best_width;
            n_best_start = r_best_start;
            n_best_end   = r_best_end;
            n_best_dist  = r_best_dist;
        end

        below     = i_req.dist_cm < i_threshold;
        open_obj  = below && !n_inside;
        close_obj = !below && n_inside;
        width     = (i_req.angle >= n_open_start) ?
                    irseg_pkg::ANGLE_W'(i_req.angle - n_open_start) : '0;
        take      = close_obj && (n_tally < TALLY_MAX) &&
                    (!n_best_valid || width < n_best_width);

        o_res = '0;
        o_res.distance_cm = i_req.dist_cm;
        if (close_obj) begin
            o_res.object_closed      = 1'b1;
            o_res.closed_start_angle = n_open_start;
            o_res.closed_end_angle   = i_req.angle;
            o_res.closed_distance    = i_req.dist_cm;
        end

        if (open_obj) begin
            n_inside     = 1'b1;
            n_open_start = i_req.angle;
        end else if (close_obj) begin
            n_inside = 1'b0;
            if (n_tally < TALLY_MAX) begin
                n_tally = irseg_pkg::TALLY_W'(n_tally + 1'b1);
            end
            if (take) begin
                n_best_valid = 1'b1;
                n_best_width = width;
                n_best_start = o_res.closed_start_angle;
                n_best_end   = i_req.angle;
                n_best_dist  = i_req.dist_cm;
            end
        end

        o_res.objects_found = n_tally;
        o_res.sweep_done    = i_req.last;
        if (i_req.last && n_best_valid) begin
            o_res.smallest_valid    = 1'b1;
            o_res.smallest_start    = n_best_start;
            o_res.smallest_end      = n_best_end;
            o_res.smallest_distance = n_best_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside     <= 1'b0;
            r_open_start <= '0;
            r_tally      <= '0;
            r_best_valid <= 1'b0;
            r_best_width <= '0;
            r_best_start <= '0;
            r_best_end   <= '0;
            r_best_dist  <= '0;
        end else if (i_upd) begin
            r_inside     <= n_inside;
            r_open_start <= n_open_start;
            r_tally      <= n_tally;
            r_best_valid <= n_best_valid;
            r_best_width <= n_best_width;
            r_best_start <= n_best_start;
            r_best_end   <= n_best_end;
            r_best_dist  <= n_best_dist;
        end
    end

endmodule

`default_nettype wire
